@@ hdl/abte_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// abte_pkg
// Shared types and constants for the array-held binary tree engine: request
// and response beats, action and status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package abte_pkg;

    localparam int ACTION_W        = 3;
    localparam int VALUE_W         = 8;
    localparam int STATUS_W        = 3;
    localparam int INDEX_W         = 5;
    localparam int CNT_W           = 5;
    localparam int MAX_RESULTS     = 31;
    localparam int DEF_TABLE_DEPTH = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_START     = 3'd0,
        ACT_INSERT    = 3'd1,
        ACT_SEARCH    = 3'd2,
        ACT_DELETE    = 3'd3,
        ACT_INORDER   = 3'd4,
        ACT_PREORDER  = 3'd5,
        ACT_POSTORDER = 3'd6,
        ACT_NONE      = 3'd7
    } action_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_OCCUPIED  = 3'd2,
        ST_NOT_LEAF  = 3'd3,
        ST_NO_ROOM   = 3'd4,
        ST_EMPTY     = 3'd5
    } status_e;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [VALUE_W-1:0]  value;
        logic [VALUE_W-1:0]  parent_key;
        logic                side;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  node_index;
        logic [VALUE_W-1:0]  node_value;
        logic                last;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_WALK,
        S_CHECK,
        S_DECIDE,
        S_CHILD,
        S_FLUSH
    } state_e;

    typedef enum logic [1:0] {
        W_DOWN,
        W_FROM_L,
        W_FROM_R
    } walk_e;

    typedef enum logic [3:0] {
        RES_START,
        RES_EMPTY,
        RES_NOT_FOUND,
        RES_SEARCH,
        RES_NO_ROOM,
        RES_OCCUPIED,
        RES_INSERT,
        RES_NOT_LEAF,
        RES_DELETE,
        RES_EMIT
    } res_e;

    typedef struct packed {
        logic latch;
        logic start;
        logic walk_init;
        logic walk_step;
        logic found_load;
        logic del;
        logic ins;
        logic rd_child;
        logic stage_load;
        res_e res_sel;
        logic cnt_inc;
        logic out_load;
        logic out_last;
    } cmd_t;

    typedef struct packed {
        action_e action;
        logic    root_full;
        logic    lookup;
        logic    emit;
        logic    walk_last;
        logic    done;
        logic    match;
        logic    stg_full;
        logic    out_free;
        logic    cnt_max_next;
        logic    child_full;
        logic    no_room;
        logic    child_occ;
    } stat_t;

endpackage
`default_nettype wire

@@ hdl/array_binary_tree_engine_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// array_binary_tree_engine_unit
// Heap-indexed binary tree of 8-bit values with insert, search, leaf delete
// and in-, pre- and post-order traversal.
//
// Usage: a request beat (req, req_valid) is taken when req_stall is low; the
// unit works on one request at a time and raises req_stall until its last
// response beat has entered the output register. Each request gives one
// response beat (action code 7 gives none); traversals give one beat per
// node, up to 31, with last set on the final one.
// Start and empty-tree answers need no walk. Lookups and traversals run
// a walker that makes one move per cycle while it walks (three moves per
// visited node) and pauses at each node it hands over for the registered
// store read.
// Reset empties the tree at once through the occupancy bits; the store data
// itself is not cleared. While rsp_stall is high the response register holds
// its beat; the walker then pauses at a node to hand over if staging is full.
// ----------------------------------------------------------------------------
module array_binary_tree_engine_unit
    import abte_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  req_valid,
    output logic       req_stall,
    input  in_item_t   req,
    output logic       rsp_valid,
    input  wire logic  rsp_stall,
    output out_item_t  rsp
);

    cmd_t  cmd;
    stat_t stat;

    abte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    abte_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

@@ hdl/abte_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// abte_ctrl
// Sequencer for the tree engine: takes a request, dispatches it, steps the
// tree walker, resolves lookups and hands beats to the response register.
// ----------------------------------------------------------------------------
module abte_ctrl
    import abte_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  req_valid,
    output logic       req_stall,
    input  stat_t      stat,
    output cmd_t       cmd
);

    state_e state_reg;
    state_e state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.action == ACT_NONE)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.action == ACT_START || !stat.root_full)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (stat.emit)
                begin
                    state_next = S_CHECK;
                end
                else if (stat.walk_last)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_CHECK:
            begin
                if (stat.lookup)
                begin
                    if (stat.match)
                    begin
                        state_next = S_DECIDE;
                    end
                    else if (stat.done)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
                else if (!stat.stg_full || stat.out_free)
                begin
                    if (stat.done || stat.cnt_max_next)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_DECIDE:
            begin
                if (stat.action == ACT_INSERT && !stat.no_room && stat.child_occ)
                begin
                    state_next = S_CHILD;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_CHILD:
            begin
                state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.latch = req_valid;
            end
            S_DISPATCH:
            begin
                if (stat.action == ACT_NONE)
                begin
                    cmd.latch = 1'b0;
                end
                else if (stat.action == ACT_START)
                begin
                    cmd.start      = 1'b1;
                    cmd.stage_load = 1'b1;
                    cmd.res_sel    = RES_START;
                end
                else if (!stat.root_full)
                begin
                    cmd.stage_load = 1'b1;
                    cmd.res_sel    = RES_EMPTY;
                end
                else
                begin
                    cmd.walk_init = 1'b1;
                end
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (!stat.emit && stat.walk_last && stat.lookup)
                begin
                    cmd.stage_load = 1'b1;
                    cmd.res_sel    = RES_NOT_FOUND;
                end
            end
            S_CHECK:
            begin
                if (stat.lookup)
                begin
                    if (stat.match)
                    begin
                        cmd.found_load = 1'b1;
                    end
                    else if (stat.done)
                    begin
                        cmd.stage_load = 1'b1;
                        cmd.res_sel    = RES_NOT_FOUND;
                    end
                end
                else if (!stat.stg_full || stat.out_free)
                begin
                    cmd.out_load   = stat.stg_full;
                    cmd.out_last   = 1'b0;
                    cmd.stage_load = 1'b1;
                    cmd.res_sel    = RES_EMIT;
                    cmd.cnt_inc    = 1'b1;
                end
            end
            S_DECIDE:
            begin
                priority case (stat.action)
                    ACT_SEARCH:
                    begin
                        cmd.stage_load = 1'b1;
                        cmd.res_sel    = RES_SEARCH;
                    end
                    ACT_DELETE:
                    begin
                        cmd.stage_load = 1'b1;
                        if (stat.child_full)
                        begin
                            cmd.res_sel = RES_NOT_LEAF;
                        end
                        else
                        begin
                            cmd.del     = 1'b1;
                            cmd.res_sel = RES_DELETE;
                        end
                    end
                    ACT_INSERT:
                    begin
                        if (stat.no_room)
                        begin
                            cmd.stage_load = 1'b1;
                            cmd.res_sel    = RES_NO_ROOM;
                        end
                        else if (stat.child_occ)
                        begin
                            cmd.rd_child = 1'b1;
                        end
                        else
                        begin
                            cmd.ins        = 1'b1;
                            cmd.stage_load = 1'b1;
                            cmd.res_sel    = RES_INSERT;
                        end
                    end
                    default:
                    begin
                        cmd.stage_load = 1'b0;
                    end
                endcase
            end
            S_CHILD:
            begin
                cmd.stage_load = 1'b1;
                cmd.res_sel    = RES_OCCUPIED;
            end
            S_FLUSH:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_last = 1'b1;
            end
            default:
            begin
                cmd.latch = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/abte_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// abte_dpath
// Node store, occupancy bits, stackless heap walker, result staging and the
// response register of the tree engine.
// ----------------------------------------------------------------------------
module abte_dpath
    import abte_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  in_item_t   req,
    input  cmd_t       cmd,
    output stat_t      stat,
    input  wire logic  rsp_stall,
    output logic       rsp_valid,
    output out_item_t  rsp
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int OCC_N = 1 << IDX_W;
    localparam logic [IDX_W-1:0] ROOT = IDX_W'(1);
    localparam logic [IDX_W:0] DEPTH_C = (IDX_W + 1)'(TABLE_DEPTH);

    logic [VALUE_W-1:0]  mem [TABLE_DEPTH];
    logic [VALUE_W-1:0]  rd_data_reg;
    in_item_t            item_reg;
    logic [OCC_N-1:0]    occ_reg;
    logic [OCC_N-1:0]    occ_next;
    logic [IDX_W-1:0]    cursor_reg;
    logic [IDX_W-1:0]    cursor_next;
    walk_e               mode_reg;
    walk_e               mode_next;
    logic                done_reg;
    logic                done_next;
    logic [IDX_W-1:0]    eidx_reg;
    logic [IDX_W-1:0]    found_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [STATUS_W-1:0] stg_status_reg;
    logic [STATUS_W-1:0] stg_status_next;
    logic [INDEX_W-1:0]  stg_index_reg;
    logic [INDEX_W-1:0]  stg_index_next;
    logic [VALUE_W-1:0]  stg_value_reg;
    logic [VALUE_W-1:0]  stg_value_next;
    logic                stg_full_reg;
    logic                stg_full_next;
    out_item_t           rsp_reg;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;

    action_e             act;
    logic                lookup;
    logic                pre_ord;
    logic [VALUE_W-1:0]  key;
    logic [IDX_W:0]      left;
    logic [IDX_W:0]      right;
    logic [IDX_W:0]      child;
    logic [IDX_W:0]      found_l;
    logic [IDX_W:0]      found_r;
    logic                emit;
    logic                walk_last;
    logic                out_free;
    logic                mem_we;
    logic [IDX_W-1:0]    waddr;
    logic                rd_en;
    logic [IDX_W-1:0]    raddr;

    function automatic logic slot_full(input logic [IDX_W:0] idx, input logic [OCC_N-1:0] occ);
        return (idx < DEPTH_C) && occ[idx[IDX_W-1:0]];
    endfunction

    assign act     = action_e'(item_reg.action);
    assign lookup  = (act == ACT_INSERT) || (act == ACT_SEARCH) || (act == ACT_DELETE);
    assign pre_ord = lookup || (act == ACT_PREORDER);
    assign key     = (act == ACT_INSERT) ? item_reg.parent_key : item_reg.value;
    assign left    = {cursor_reg, 1'b0};
    assign right   = {cursor_reg, 1'b1};
    assign child   = {found_reg, item_reg.side};
    assign found_l = {found_reg, 1'b0};
    assign found_r = {found_reg, 1'b1};
    assign out_free = !rsp_valid_reg || !rsp_stall;

    // Walker: one move per cycle while walk_step is set, emit point set by the traversal order.
    always_comb
    begin
        cursor_next = cursor_reg;
        mode_next   = mode_reg;
        emit        = 1'b0;
        walk_last   = 1'b0;
        unique case (mode_reg)
            W_DOWN:
            begin
                emit = pre_ord;
                if (slot_full(left, occ_reg))
                begin
                    cursor_next = left[IDX_W-1:0];
                end
                else
                begin
                    mode_next = W_FROM_L;
                end
            end
            W_FROM_L:
            begin
                emit = (act == ACT_INORDER);
                if (slot_full(right, occ_reg))
                begin
                    cursor_next = right[IDX_W-1:0];
                    mode_next   = W_DOWN;
                end
                else
                begin
                    mode_next = W_FROM_R;
                end
            end
            W_FROM_R:
            begin
                emit = (act == ACT_POSTORDER);
                if (cursor_reg == ROOT)
                begin
                    walk_last = 1'b1;
                end
                else
                begin
                    cursor_next = cursor_reg >> 1;
                    mode_next   = cursor_reg[0] ? W_FROM_R : W_FROM_L;
                end
            end
            default:
            begin
                mode_next = W_DOWN;
            end
        endcase
        if (cmd.walk_init)
        begin
            cursor_next = ROOT;
            mode_next   = W_DOWN;
        end
        else if (!cmd.walk_step)
        begin
            cursor_next = cursor_reg;
            mode_next   = mode_reg;
        end
    end

    always_comb
    begin
        done_next = done_reg;
        if (cmd.walk_init)
        begin
            done_next = 1'b0;
        end
        else if (cmd.walk_step)
        begin
            done_next = walk_last;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.walk_init)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (cmd.start)
        begin
            occ_next       = '0;
            occ_next[ROOT] = (item_reg.value != '0);
        end
        if (cmd.ins)
        begin
            occ_next[child[IDX_W-1:0]] = (item_reg.value != '0);
        end
        if (cmd.del)
        begin
            occ_next[found_reg] = 1'b0;
        end
    end

    always_comb
    begin
        stg_status_next = ST_OK;
        stg_index_next  = '0;
        stg_value_next  = '0;
        unique case (cmd.res_sel)
            RES_START:
            begin
                if (item_reg.value == '0)
                begin
                    stg_status_next = ST_EMPTY;
                end
                else
                begin
                    stg_index_next = INDEX_W'(ROOT);
                    stg_value_next = item_reg.value;
                end
            end
            RES_EMPTY:
            begin
                stg_status_next = ST_EMPTY;
            end
            RES_NOT_FOUND:
            begin
                stg_status_next = ST_NOT_FOUND;
            end
            RES_SEARCH:
            begin
                stg_index_next = INDEX_W'(found_reg);
                stg_value_next = rd_data_reg;
            end
            RES_NO_ROOM:
            begin
                stg_status_next = ST_NO_ROOM;
            end
            RES_OCCUPIED:
            begin
                stg_status_next = ST_OCCUPIED;
                stg_index_next  = INDEX_W'(child);
                stg_value_next  = rd_data_reg;
            end
            RES_INSERT:
            begin
                stg_index_next = INDEX_W'(child);
                stg_value_next = item_reg.value;
            end
            RES_NOT_LEAF:
            begin
                stg_status_next = ST_NOT_LEAF;
                stg_index_next  = INDEX_W'(found_reg);
                stg_value_next  = item_reg.value;
            end
            RES_DELETE:
            begin
                stg_index_next = INDEX_W'(found_reg);
                stg_value_next = item_reg.value;
            end
            RES_EMIT:
            begin
                stg_index_next = INDEX_W'(eidx_reg);
                stg_value_next = rd_data_reg;
            end
            default:
            begin
                stg_status_next = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        stg_full_next = stg_full_reg;
        if (cmd.stage_load)
        begin
            stg_full_next = 1'b1;
        end
        else if (cmd.out_load)
        begin
            stg_full_next = 1'b0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    assign mem_we = cmd.start || cmd.ins;
    assign waddr  = cmd.start ? ROOT : child[IDX_W-1:0];
    assign rd_en  = (cmd.walk_step && emit) || cmd.rd_child;
    assign raddr  = cmd.rd_child ? child[IDX_W-1:0] : cursor_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= item_reg.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg <= req;
        end
        if (cmd.walk_step && emit)
        begin
            eidx_reg <= cursor_reg;
        end
        if (cmd.found_load)
        begin
            found_reg <= eidx_reg;
        end
        if (cmd.stage_load)
        begin
            stg_status_reg <= stg_status_next;
            stg_index_reg  <= stg_index_next;
            stg_value_reg  <= stg_value_next;
        end
        if (cmd.out_load)
        begin
            rsp_reg.status     <= stg_status_reg;
            rsp_reg.node_index <= stg_index_reg;
            rsp_reg.node_value <= stg_value_reg;
            rsp_reg.last       <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            cursor_reg    <= ROOT;
            mode_reg      <= W_DOWN;
            done_reg      <= 1'b0;
            cnt_reg       <= '0;
            stg_full_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            cursor_reg    <= cursor_next;
            mode_reg      <= mode_next;
            done_reg      <= done_next;
            cnt_reg       <= cnt_next;
            stg_full_reg  <= stg_full_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign stat.action       = act;
    assign stat.root_full    = occ_reg[ROOT];
    assign stat.lookup       = lookup;
    assign stat.emit         = emit;
    assign stat.walk_last    = walk_last;
    assign stat.done         = done_reg;
    assign stat.match        = (rd_data_reg == key);
    assign stat.stg_full     = stg_full_reg;
    assign stat.out_free     = out_free;
    assign stat.cnt_max_next = (cnt_reg == CNT_W'(MAX_RESULTS - 1));
    assign stat.child_full   = slot_full(found_l, occ_reg) || slot_full(found_r, occ_reg);
    assign stat.no_room      = (child >= DEPTH_C);
    assign stat.child_occ    = occ_reg[child[IDX_W-1:0]];

endmodule
`default_nettype wire
